/* sv/amte_pkg.sv */
// Shared types, constants and the Morse code table for the pulse encoder.
`default_nettype none

package amte_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned PAT_W    = 5;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned NUM_CODES = 36;
    localparam int unsigned NUM_LETTERS = 26;

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFS  = 8'h20;

    localparam logic [TIME_W-1:0] DOT_ON_RESET     = 16'd200;
    localparam logic [TIME_W-1:0] DASH_ON_RESET    = 16'd600;
    localparam logic [TIME_W-1:0] SYM_GAP_RESET    = 16'd200;
    localparam logic [TIME_W-1:0] LETTER_GAP_RESET = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT_ON     = 8'd0,
        CFG_DASH_ON    = 8'd1,
        CFG_SYM_GAP    = 8'd2,
        CFG_LETTER_GAP = 8'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_SPACE,
        ST_CLOSE
    } t_back_state;

    typedef struct packed {
        logic [TIME_W-1:0] dot_on;
        logic [TIME_W-1:0] dash_on;
        logic [TIME_W-1:0] sym_gap;
        logic [TIME_W-1:0] letter_gap;
    } t_cfg;

    // One classified character; pattern is left aligned, first symbol in
    // the top bit, 1 = dash.
    typedef struct packed {
        logic             known;
        logic [CNT_W-1:0] count;
        logic [PAT_W-1:0] pattern;
    } t_desc;

    // A-Z then 0-9.
    localparam logic [CNT_W-1:0] SYM_COUNT [NUM_CODES] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    localparam logic [PAT_W-1:0] SYM_BITS [NUM_CODES] = '{
        5'd1,  5'd8,  5'd10, 5'd4,  5'd0,  5'd2,  5'd6,  5'd0,  5'd0,  5'd7,
        5'd5,  5'd4,  5'd3,  5'd2,  5'd7,  5'd6,  5'd13, 5'd2,  5'd0,  5'd1,
        5'd1,  5'd1,  5'd3,  5'd9,  5'd11, 5'd12,
        5'd31, 5'd15, 5'd7,  5'd3,  5'd1,  5'd0,  5'd16, 5'd24, 5'd28, 5'd30
    };

    function automatic t_desc classify(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        logic [5:0]        slot;
        logic              hit;
        t_desc             d;
        u    = c;
        slot = '0;
        hit  = 1'b0;
        d    = '0;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            u = c - CASE_OFFS;
        end
        if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
            slot = 6'(u - CH_UPPER_A);
            hit  = 1'b1;
        end else if (u >= CH_ZERO && u <= CH_NINE) begin
            slot = 6'(u - CH_ZERO) + 6'(NUM_LETTERS);
            hit  = 1'b1;
        end
        if (hit) begin
            d.known   = 1'b1;
            d.count   = SYM_COUNT[slot];
            d.pattern = PAT_W'(SYM_BITS[slot] << (3'(PAT_W) - SYM_COUNT[slot]));
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* sv/amte_front.sv */
// Front end: takes characters, folds case and looks up the Morse code.
`default_nettype none

module amte_front (
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [amte_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output amte_pkg::t_desc                    o_q_desc
);

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;
    assign o_q_desc = amte_pkg::classify(i_char_code);

endmodule

`default_nettype wire

/* sv/amte_fifo.sv */
// Small descriptor queue between the front end and the pulse sequencer.
`default_nettype none

module amte_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  amte_pkg::t_desc      i_desc,
    output logic                 o_full,
    input  wire logic            i_pop,
    output amte_pkg::t_desc      o_desc,
    output logic                 o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    amte_pkg::t_desc  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count beyond depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not drop on request taken");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not rise on request stored");

endmodule

`default_nettype wire

/* sv/amte_back.sv */
// Pulse sequencer: turns a code descriptor into timed lamp intervals.
`default_nettype none

module amte_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  amte_pkg::t_cfg                   i_cfg,
    input  wire logic                        i_q_empty,
    input  amte_pkg::t_desc                  i_q_desc,
    output logic                             o_q_pop,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic                             o_lamp_on,
    output logic [amte_pkg::TIME_W-1:0]      o_interval_length,
    output logic                             o_unknown_char,
    output logic                             o_last_of_run
);

    amte_pkg::t_back_state              r_state, n_state;
    logic [amte_pkg::CNT_W-1:0]         r_cnt;
    logic [amte_pkg::PAT_W-1:0]         r_bits;
    logic                               r_unk;

    logic                               r_ovalid;
    logic                               r_olamp;
    logic [amte_pkg::TIME_W-1:0]        r_olen;
    logic                               r_ounk;
    logic                               r_olast;

    logic                               out_taken;
    logic                               can_load;
    logic                               emit;
    logic                               e_lamp;
    logic [amte_pkg::TIME_W-1:0]        e_len;
    logic                               e_unk;
    logic                               e_last;

    assign out_taken = i_pop && r_ovalid;
    assign can_load  = !r_ovalid || i_pop;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amte_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_desc.known ? amte_pkg::ST_MARK : amte_pkg::ST_CLOSE;
                end
            end
            amte_pkg::ST_MARK: begin
                if (can_load) begin
                    n_state = amte_pkg::ST_SPACE;
                end
            end
            amte_pkg::ST_SPACE: begin
                if (can_load) begin
                    n_state = (r_cnt == amte_pkg::CNT_W'(1)) ? amte_pkg::ST_CLOSE
                                                               : amte_pkg::ST_MARK;
                end
            end
            amte_pkg::ST_CLOSE: begin
                if (can_load) begin
                    n_state = amte_pkg::ST_IDLE;
                end
            end
            default: n_state = amte_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop = 1'b0;
        emit    = 1'b0;
        e_lamp  = 1'b0;
        e_len   = i_cfg.letter_gap;
        e_unk   = 1'b0;
        e_last  = 1'b0;
        unique case (r_state)
            amte_pkg::ST_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            amte_pkg::ST_MARK: begin
                emit   = can_load;
                e_lamp = 1'b1;
                e_len  = r_bits[amte_pkg::PAT_W-1] ? i_cfg.dash_on : i_cfg.dot_on;
            end
            amte_pkg::ST_SPACE: begin
                emit  = can_load;
                e_len = i_cfg.sym_gap;
            end
            amte_pkg::ST_CLOSE: begin
                emit   = can_load;
                e_unk  = r_unk;
                e_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= amte_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (out_taken) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cnt  <= i_q_desc.count;
            r_bits <= i_q_desc.pattern;
            r_unk  <= !i_q_desc.known;
        end else if (emit && r_state == amte_pkg::ST_MARK) begin
            r_bits <= {r_bits[amte_pkg::PAT_W-2:0], 1'b0};
        end else if (emit && r_state == amte_pkg::ST_SPACE) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (emit) begin
            r_olamp <= e_lamp;
            r_olen  <= e_len;
            r_ounk  <= e_unk;
            r_olast <= e_last;
        end
    end

    assign o_empty           = !r_ovalid;
    assign o_lamp_on         = r_olamp;
    assign o_interval_length = r_olen;
    assign o_unknown_char    = r_ounk;
    assign o_last_of_run     = r_olast;

    a_last_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> !r_olamp)
        else $error("closing interval has lamp lit");

    a_unknown_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ounk) |-> r_olast)
        else $error("unknown flag on a non-closing interval");

    a_symbols_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amte_pkg::ST_MARK || r_state == amte_pkg::ST_SPACE)
            |-> (r_cnt != '0))
        else $error("symbol interval with no symbols left");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!i_q_empty && r_state == amte_pkg::ST_IDLE))
        else $error("descriptor taken from empty queue or while busy");

endmodule

`default_nettype wire

/* sv/ascii_to_morse_pulse_encoder_unit.sv */
// Top level of the ASCII to Morse pulse encoder.
`default_nettype none

// Each character pushed in becomes a run of lamp intervals: for every dot or
// dash an on interval and a symbol-gap off interval, then one closing
// letter-gap interval flagged last_of_run (alone, and flagged unknown_char,
// for bytes outside A-Z, a-z and 0-9). The front end classifies a character
// in the cycle it is pushed and parks it in a QUEUE_DEPTH-entry queue; the
// sequencer takes a queued character only when idle, then emits its
// intervals one after another and takes no new character until the closing
// interval is out. The result register holds one interval, and stalls on
// the pop side back up through the sequencer and the queue to full.
// Timing registers are written through the cfg channel, which is always
// ready; write them only while the block is idle.
module ascii_to_morse_pulse_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [amte_pkg::CHAR_W-1:0]       i_char_code,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   o_lamp_on,
    output logic [amte_pkg::TIME_W-1:0]            o_interval_length,
    output logic                                   o_unknown_char,
    output logic                                   o_last_of_run,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [amte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [amte_pkg::TIME_W-1:0]       i_cfg_data
);

    amte_pkg::t_cfg  r_cfg;
    amte_pkg::t_desc front_desc;
    amte_pkg::t_desc q_desc;
    logic            q_full;
    logic            q_push;
    logic            q_empty;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_on     <= amte_pkg::DOT_ON_RESET;
            r_cfg.dash_on    <= amte_pkg::DASH_ON_RESET;
            r_cfg.sym_gap    <= amte_pkg::SYM_GAP_RESET;
            r_cfg.letter_gap <= amte_pkg::LETTER_GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                amte_pkg::CFG_DOT_ON:     r_cfg.dot_on     <= i_cfg_data;
                amte_pkg::CFG_DASH_ON:    r_cfg.dash_on    <= i_cfg_data;
                amte_pkg::CFG_SYM_GAP:    r_cfg.sym_gap    <= i_cfg_data;
                amte_pkg::CFG_LETTER_GAP: r_cfg.letter_gap <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    amte_front u_front (
        .i_push      (push),
        .o_full      (full),
        .i_char_code (i_char_code),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_desc    (front_desc)
    );

    amte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_desc  (q_desc),
        .o_empty (q_empty)
    );

    amte_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_empty         (q_empty),
        .i_q_desc          (q_desc),
        .o_q_pop           (q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_lamp_on         (o_lamp_on),
        .o_interval_length (o_interval_length),
        .o_unknown_char    (o_unknown_char),
        .o_last_of_run     (o_last_of_run)
    );

endmodule

`default_nettype wire

/* tb/tb_ascii_to_morse_pulse_encoder_unit.sv */
// Self-checking testbench: directed and random characters through the Morse pulse encoder.
module tb_ascii_to_morse_pulse_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD       = 10;
    localparam int unsigned RESET_CYCLES     = 9;
    localparam int unsigned NUM_CFG_REGS     = 4;
    localparam int unsigned RANDOM_PER_PHASE = 15;
    localparam int unsigned DRAIN_LIMIT      = 4000;
    localparam int unsigned TAIL_CYCLES      = 16;
    localparam int unsigned NUM_DIRECTED     = 21;
    localparam longint unsigned TIMEOUT_NS   = 5_000_000;
    localparam logic [amte_pkg::CFG_IDX_W-1:0] CFG_IDX_OUT_OF_RANGE = 8'hFF;

    typedef struct packed {
        logic                        lamp_on;
        logic [amte_pkg::TIME_W-1:0] length;
        logic                        unknown_char;
        logic                        last_of_run;
    } t_interval;

    typedef struct {
        logic [amte_pkg::CHAR_W-1:0] code;
        bit                          typed;
        t_interval                   typed_close;
    } t_char_row;

    // With reset timing an uncoded byte gives just the dark letter gap.
    localparam t_interval UNCODED_AT_RESET = '{1'b0, 16'd400, 1'b1, 1'b1};
    localparam t_interval NO_TYPED         = '0;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [amte_pkg::CHAR_W-1:0]    i_char_code;
    logic                           empty;
    logic                           pop;
    logic                           o_lamp_on;
    logic [amte_pkg::TIME_W-1:0]    o_interval_length;
    logic                           o_unknown_char;
    logic                           o_last_of_run;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [amte_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [amte_pkg::TIME_W-1:0]    i_cfg_data;

    amte_pkg::t_cfg timing;
    t_interval pending_intervals [$];
    int        error_count       = 0;
    int        intervals_checked = 0;
    int        chars_sent        = 0;
    int        uncoded_sent      = 0;
    int        settings_used     = 1;
    bit        sender_calm       = 1'b0;

    t_char_row directed_rows [NUM_DIRECTED] = '{
        '{8'h00, 1'b1, UNCODED_AT_RESET},
        '{8'hFF, 1'b1, UNCODED_AT_RESET},
        '{8'h20, 1'b1, UNCODED_AT_RESET},
        '{8'h2F, 1'b1, UNCODED_AT_RESET},
        '{"0",   1'b0, NO_TYPED},
        '{"9",   1'b0, NO_TYPED},
        '{8'h3A, 1'b1, UNCODED_AT_RESET},
        '{8'h40, 1'b1, UNCODED_AT_RESET},
        '{"A",   1'b0, NO_TYPED},
        '{"Z",   1'b0, NO_TYPED},
        '{8'h5B, 1'b1, UNCODED_AT_RESET},
        '{8'h60, 1'b1, UNCODED_AT_RESET},
        '{"a",   1'b0, NO_TYPED},
        '{"z",   1'b0, NO_TYPED},
        '{8'h7B, 1'b1, UNCODED_AT_RESET},
        '{8'h80, 1'b1, UNCODED_AT_RESET},
        '{"E",   1'b0, NO_TYPED},
        '{"T",   1'b0, NO_TYPED},
        '{"5",   1'b0, NO_TYPED},
        '{"Q",   1'b0, NO_TYPED},
        '{"y",   1'b0, NO_TYPED}
    };

    ascii_to_morse_pulse_encoder_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_char_code       (i_char_code),
        .empty             (empty),
        .pop               (pop),
        .o_lamp_on         (o_lamp_on),
        .o_interval_length (o_interval_length),
        .o_unknown_char    (o_unknown_char),
        .o_last_of_run     (o_last_of_run),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TIMEOUT: %0d intervals still outstanding", pending_intervals.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Dots and dashes of a character, empty when it has no code.
    function automatic string morse_of(input logic [amte_pkg::CHAR_W-1:0] ch);
        logic [amte_pkg::CHAR_W-1:0] up;
        up = (ch >= "a" && ch <= "z") ? amte_pkg::CHAR_W'(ch - ("a" - "A")) : ch;
        case (up)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    task automatic predict_intervals(input logic [amte_pkg::CHAR_W-1:0] ch);
        string code;
        code = morse_of(ch);
        for (int i = 0; i < code.len(); i++) begin
            pending_intervals.push_back(t_interval'{1'b1,
                (code[i] == "-") ? timing.dash_on : timing.dot_on, 1'b0, 1'b0});
            pending_intervals.push_back(t_interval'{1'b0, timing.sym_gap, 1'b0, 1'b0});
        end
        pending_intervals.push_back(t_interval'{1'b0, timing.letter_gap,
            (code.len() == 0), 1'b1});
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            report_error($sformatf("interval %0d %s: expected %0d got %0d",
                intervals_checked, name, want, got));
        end
    endtask

    task automatic check_interval(input t_interval got);
        t_interval want;
        if (pending_intervals.size() == 0) begin
            report_error($sformatf("unexpected interval lamp=%0d len=%0d unk=%0d last=%0d",
                got.lamp_on, got.length, got.unknown_char, got.last_of_run));
            return;
        end
        want = pending_intervals.pop_front();
        compare_field("lamp_on",         want.lamp_on,      got.lamp_on);
        compare_field("interval_length", want.length,       got.length);
        compare_field("unknown_char",    want.unknown_char, got.unknown_char);
        compare_field("last_of_run",     want.last_of_run,  got.last_of_run);
        intervals_checked++;
    endtask

    // Result side: pop with a random stall per interval, with calm stretches.
    initial begin : result_side
        t_interval got;
        int        stall_left;
        int        since_mode;
        bit        calm;
        pop        = 1'b0;
        stall_left = 0;
        since_mode = 0;
        calm       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                got = '{o_lamp_on, o_interval_length, o_unknown_char, o_last_of_run};
                check_interval(got);
                since_mode++;
                if (since_mode == 24) begin
                    since_mode = 0;
                    calm = ($urandom_range(0, 2) == 0);
                end
                stall_left = calm ? 0 : $urandom_range(0, 9);
            end
        end
    end

    task automatic send_char(input logic [amte_pkg::CHAR_W-1:0] ch, input bit typed,
                             input t_interval typed_close);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push        <= 1'b1;
        i_char_code <= ch;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (typed) begin
            pending_intervals.push_back(typed_close);
        end else begin
            predict_intervals(ch);
        end
        chars_sent++;
        if (morse_of(ch).len() == 0) uncoded_sent++;
    endtask

    // Drop push and hold until every outstanding interval has been popped.
    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_intervals.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_intervals.size() != 0) begin
            report_error($sformatf("%0d intervals never arrived", pending_intervals.size()));
            pending_intervals.delete();
        end
    endtask

    task automatic write_reg(input logic [amte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [amte_pkg::TIME_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            amte_pkg::CFG_DOT_ON:     timing.dot_on     = val;
            amte_pkg::CFG_DASH_ON:    timing.dash_on    = val;
            amte_pkg::CFG_SYM_GAP:    timing.sym_gap    = val;
            amte_pkg::CFG_LETTER_GAP: timing.letter_gap = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Idle the block, load all four timings, then poke an unused index.
    task automatic apply_timing(input logic [amte_pkg::TIME_W-1:0] dot,
                                input logic [amte_pkg::TIME_W-1:0] dash,
                                input logic [amte_pkg::TIME_W-1:0] sym,
                                input logic [amte_pkg::TIME_W-1:0] letter);
        wait_drained();
        write_reg(amte_pkg::CFG_DOT_ON, dot);
        write_reg(amte_pkg::CFG_DASH_ON, dash);
        write_reg(amte_pkg::CFG_SYM_GAP, sym);
        write_reg(amte_pkg::CFG_LETTER_GAP, letter);
        write_reg(amte_pkg::CFG_IDX_W'($urandom_range(NUM_CFG_REGS, 255)),
                  amte_pkg::TIME_W'($urandom));
        settings_used++;
        sender_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Mostly coded characters in both cases, with raw bytes mixed in.
    function automatic logic [amte_pkg::CHAR_W-1:0] random_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return amte_pkg::CHAR_W'("A" + $urandom_range(0, 25));
            3, 4:    return amte_pkg::CHAR_W'("a" + $urandom_range(0, 25));
            5, 6:    return amte_pkg::CHAR_W'("0" + $urandom_range(0, 9));
            default: return amte_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 19) == 0) wait_drained();
            send_char(random_char(), 1'b0, NO_TYPED);
        end
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_char_code = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        timing      = '{amte_pkg::DOT_ON_RESET, amte_pkg::DASH_ON_RESET,
                        amte_pkg::SYM_GAP_RESET, amte_pkg::LETTER_GAP_RESET};
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_char(directed_rows[r].code, directed_rows[r].typed,
                      directed_rows[r].typed_close);
        end
        run_random(RANDOM_PER_PHASE);

        apply_timing(16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(CFG_IDX_OUT_OF_RANGE, 16'hFFFF);
        run_random(RANDOM_PER_PHASE);

        apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_PHASE);

        apply_timing(16'd1, 16'hFFFE, 16'h5555, 16'hAAAA);
        run_random(RANDOM_PER_PHASE);

        repeat (2) begin
            apply_timing(amte_pkg::TIME_W'($urandom), amte_pkg::TIME_W'($urandom),
                         amte_pkg::TIME_W'($urandom), amte_pkg::TIME_W'($urandom));
            run_random(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters (%0d with no Morse code) under %0d timing settings,",
                 chars_sent, uncoded_sent, settings_used);
        $display("zero and full-scale timings included; %0d lamp intervals compared.",
                 intervals_checked);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
